/* design/pdec_pkg.sv */
// Shared types and codes for the PS/2 mouse packet decoder.
// No dependencies; every design file imports this package.
package pdec_pkg;

  localparam int unsigned ButtonCount = 4;
  localparam int unsigned EventBits   = ButtonCount + 1;
  localparam int unsigned QueueDepth  = 2;

  typedef enum logic [1:0] {
    EV_MOVE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2
  } event_kind_t;

  // One completed packet; ev_mask bit 0 is motion, bits 1..4 are button changes.
  typedef struct packed {
    logic [EventBits-1:0]   ev_mask;
    logic [ButtonCount-1:0] buttons;
    logic [7:0]             dx;
    logic [7:0]             dy_raw;
  } pkt_desc_t;

  typedef struct packed {
    event_kind_t        kind;
    logic [2:0]         button;
    logic signed [7:0]  dx;
    logic signed [8:0]  dy;
    logic               last;
  } mouse_event_t;

endpackage

/* design/pdec_front.sv */
// Front end: collects flagged bytes into three-byte packets and classifies them.
// Depends on pdec_pkg; feeds pdec_queue.
module pdec_front
  import pdec_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  logic      in_aux_flag,
  input  logic [7:0] in_data_byte,
  input  logic      q_full,
  output logic      q_push,
  output pkt_desc_t q_desc
);

  logic [1:0]             pos_r, pos_nxt;
  logic [7:0]             pkt0_r, pkt1_r;
  logic [ButtonCount-1:0] prev_r, prev_nxt;
  logic                   take;
  logic                   complete;
  logic [ButtonCount-1:0] change;
  logic                   move;

  assign in_full  = q_full;
  assign take     = in_push & ~q_full & in_aux_flag;
  assign complete = take & pos_r[1];
  assign change   = pkt0_r[ButtonCount-1:0] ^ prev_r;
  assign move     = (pkt1_r != 8'd0) || (in_data_byte != 8'd0);

  always_comb begin
    pos_nxt  = pos_r;
    prev_nxt = prev_r;
    if (take) begin
      if (pos_r[1]) begin
        pos_nxt  = 2'd0;
        prev_nxt = pkt0_r[ButtonCount-1:0];
      end else begin
        pos_nxt = pos_r + 2'd1;
      end
    end
  end

  assign q_push         = complete & (move | (|change));
  assign q_desc.ev_mask = {change, move};
  assign q_desc.buttons = pkt0_r[ButtonCount-1:0];
  assign q_desc.dx      = pkt1_r;
  assign q_desc.dy_raw  = in_data_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 2'd0;
      prev_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      prev_r <= prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !pos_r[1]) begin
      if (pos_r[0]) begin
        pkt1_r <= in_data_byte;
      end else begin
        pkt0_r <= in_data_byte;
      end
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n) pos_r != 2'd3)
    else $error("byte position out of range");
  a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_desc.ev_mask != '0))
    else $error("packet with no events queued");
  a_prev_update: assert property (@(posedge clk) disable iff (!rst_n)
    complete |=> (prev_r == $past(pkt0_r[ButtonCount-1:0])))
    else $error("button state not updated on packet end");

endmodule

/* design/pdec_queue.sv */
// Two-entry queue of packet descriptors between front and back end.
// Depends on pdec_pkg.
module pdec_queue
  import pdec_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  pkt_desc_t push_desc,
  output logic      full,
  input  logic      pop,
  output logic      valid,
  output pkt_desc_t head
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  pkt_desc_t         mem [QueueDepth];
  logic [PtrW-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [PtrW:0]     cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = (cnt_r == (PtrW+1)'(QueueDepth));
  assign valid   = (cnt_r != '0);
  assign head    = mem[rd_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & valid;

  always_comb begin
    wr_nxt  = do_push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_r] <= push_desc;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PtrW+1)'(QueueDepth))
    else $error("descriptor queue overflow");
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("descriptor pushed into full queue");
  a_ptr_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wr_r == rd_r))
    else $error("queue pointers disagree with count");

endmodule

/* design/pdec_back.sv */
// Back end: walks each packet descriptor and emits one event per cycle, while the
// two-entry result queue has room, into that queue. Depends on pdec_pkg.
module pdec_back
  import pdec_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_valid,
  input  pkt_desc_t    q_head,
  output logic         q_pop,
  output logic         out_empty,
  input  logic         out_pop,
  output mouse_event_t out_event
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  logic [EventBits-1:0] done_r, done_nxt;
  logic [EventBits-1:0] pending, sel_mask;
  logic [2:0]           sel_idx;
  logic                 emit, room;
  mouse_event_t         ev;
  mouse_event_t         obuf [QueueDepth];
  logic [PtrW-1:0]      owr_r, ord_r;
  logic [PtrW:0]        ocnt_r, ocnt_nxt;
  logic                 o_pop;

  assign pending = q_head.ev_mask & ~done_r;

  always_comb begin
    sel_idx = 3'd0;
    for (int i = EventBits - 1; i >= 0; i--) begin
      if (pending[i]) begin
        sel_idx = 3'(i);
      end
    end
  end

  assign sel_mask = EventBits'(1) << sel_idx;
  assign room     = (ocnt_r != (PtrW+1)'(QueueDepth));
  assign emit     = q_valid & room & (pending != '0);
  assign q_pop    = emit & ((pending & ~sel_mask) == '0);

  always_comb begin
    done_nxt = done_r;
    if (q_pop) begin
      done_nxt = '0;
    end else if (emit) begin
      done_nxt = done_r | sel_mask;
    end
  end

  always_comb begin
    ev.last = ((pending & ~sel_mask) == '0);
    if (sel_idx == 3'd0) begin
      ev.kind   = EV_MOVE;
      ev.button = 3'd0;
      ev.dx     = q_head.dx;
      ev.dy     = 9'sd0 - $signed({q_head.dy_raw[7], q_head.dy_raw});
    end else begin
      ev.kind   = q_head.buttons[2'(sel_idx - 3'd1)] ? EV_PRESS : EV_RELEASE;
      ev.button = sel_idx;
      ev.dx     = '0;
      ev.dy     = '0;
    end
  end

  assign out_empty = (ocnt_r == '0);
  assign out_event = obuf[ord_r];
  assign o_pop     = out_pop & ~out_empty;

  always_comb begin
    ocnt_nxt = ocnt_r;
    if (emit && !o_pop) begin
      ocnt_nxt = ocnt_r + 1'b1;
    end else if (!emit && o_pop) begin
      ocnt_nxt = ocnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= '0;
      owr_r  <= '0;
      ord_r  <= '0;
      ocnt_r <= '0;
    end else begin
      done_r <= done_nxt;
      owr_r  <= emit ? owr_r + 1'b1 : owr_r;
      ord_r  <= o_pop ? ord_r + 1'b1 : ord_r;
      ocnt_r <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      obuf[owr_r] <= ev;
    end
  end

  a_head_live: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> (pending != '0))
    else $error("queued packet has no pending event");
  a_done_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !q_valid |-> (done_r == '0))
    else $error("progress mask set with no packet");
  a_ocnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r <= (PtrW+1)'(QueueDepth))
    else $error("result queue overflow");
  a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (q_pop == ev.last))
    else $error("descriptor retired out of step with last event");

endmodule

/* design/ps2_mouse_packet_decoder.sv */
// PS/2 mouse packet decoder top level: front end, descriptor queue, back end.
// Accepts one byte per cycle while the two-entry descriptor queue has room.
// First event of a packet is registered in the descriptor queue, then in the result queue, before it is poppable.
// Back end emits one event per cycle while the result queue has room; a packet yields 1 to 5 events.
// Synchronous active-low reset clears byte position, button state and queues.
module ps2_mouse_packet_decoder
  import pdec_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic              in_aux_flag,
  input  logic [7:0]        in_data_byte,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [1:0]        out_event_kind,
  output logic [2:0]        out_button_number,
  output logic signed [7:0] out_delta_x,
  output logic signed [8:0] out_delta_y,
  output logic              out_last_event
);

  logic         q_push, q_full, q_valid, q_pop;
  pkt_desc_t    q_desc, q_head;
  mouse_event_t ev;

  pdec_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_aux_flag  (in_aux_flag),
    .in_data_byte (in_data_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_desc       (q_desc)
  );

  pdec_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (q_desc),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  pdec_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_event (ev)
  );

  assign out_event_kind    = ev.kind;
  assign out_button_number = ev.button;
  assign out_delta_x       = ev.dx;
  assign out_delta_y       = ev.dy;
  assign out_last_event    = ev.last;

endmodule

/* tb/mouse_event_checker.sv */
// Monitor, predictor and scoreboard for the PS/2 mouse packet decoder.
// Depends on pdec_pkg; watches both queue-style channels and counts mismatches.
module mouse_event_checker
  import pdec_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic              in_full,
  input  logic              in_aux_flag,
  input  logic [7:0]        in_data_byte,
  input  logic              out_empty,
  input  logic              out_pop,
  input  logic [1:0]        out_event_kind,
  input  logic [2:0]        out_button_number,
  input  logic signed [7:0] out_delta_x,
  input  logic signed [8:0] out_delta_y,
  input  logic              out_last_event,
  output int                fail_count,
  output int                pending,
  output int                checked
);
  timeunit 1ns;
  timeprecision 1ps;

  mouse_event_t expected_events[$];
  logic [1:0]   byte_pos;
  logic [7:0]   status_byte;
  logic [7:0]   dx_byte;
  logic [3:0]   held_buttons;

  task automatic report(input string what, input logic [8:0] want, input logic [8:0] got);
    $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    fail_count++;
  endtask

  task automatic decode_byte(input logic [7:0] b);
    mouse_event_t ev;
    logic [3:0]   now;
    int           base;
    base = expected_events.size();
    if (byte_pos == 2'd0) begin
      status_byte = b;
      byte_pos = 2'd1;
    end else if (byte_pos == 2'd1) begin
      dx_byte = b;
      byte_pos = 2'd2;
    end else begin
      byte_pos = 2'd0;
      if (dx_byte != 8'd0 || b != 8'd0) begin
        ev.kind   = EV_MOVE;
        ev.button = 3'd0;
        ev.dx     = dx_byte;
        ev.dy     = -$signed({b[7], b});
        ev.last   = 1'b0;
        expected_events.push_back(ev);
      end
      now = status_byte[3:0];
      for (int i = 0; i < ButtonCount; i++) begin
        if (now[i] != held_buttons[i]) begin
          ev.kind   = held_buttons[i] ? EV_RELEASE : EV_PRESS;
          ev.button = 3'(i + 1);
          ev.dx     = '0;
          ev.dy     = '0;
          ev.last   = 1'b0;
          expected_events.push_back(ev);
        end
      end
      held_buttons = now;
      if (expected_events.size() > base) begin
        ev = expected_events.pop_back();
        ev.last = 1'b1;
        expected_events.push_back(ev);
      end
    end
  endtask

  task automatic compare_event();
    mouse_event_t ev;
    if (expected_events.size() == 0) begin
      report("unexpected event kind", 9'd0, {7'd0, out_event_kind});
    end else begin
      ev = expected_events.pop_front();
      checked++;
      if (out_event_kind != ev.kind)
        report("event_kind", {7'd0, ev.kind}, {7'd0, out_event_kind});
      if (out_button_number != ev.button)
        report("button_number", {6'd0, ev.button}, {6'd0, out_button_number});
      if (out_delta_x != ev.dx)
        report("delta_x", {1'b0, ev.dx}, {1'b0, out_delta_x});
      if (out_delta_y != ev.dy)
        report("delta_y", ev.dy, out_delta_y);
      if (out_last_event != ev.last)
        report("last_event", {8'd0, ev.last}, {8'd0, out_last_event});
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_events.delete();
      byte_pos     = 2'd0;
      status_byte  = 8'd0;
      dx_byte      = 8'd0;
      held_buttons = 4'd0;
    end else begin
      if (out_pop && !out_empty) compare_event();
      if (in_push && !in_full && in_aux_flag) decode_byte(in_data_byte);
    end
    pending = expected_events.size();
  end

endmodule

/* tb/tb_ps2_mouse_packet_decoder.sv */
// Top-level testbench for ps2_mouse_packet_decoder: clock, reset, byte stimulus and pop stalls.
// Depends on pdec_pkg, the decoder RTL and mouse_event_checker.
module tb_ps2_mouse_packet_decoder;
  timeunit 1ns;
  timeprecision 1ps;
  import pdec_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int TailCycles = 64;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_push = 1'b0;
  logic              in_aux_flag = 1'b0;
  logic [7:0]        in_data_byte = 8'd0;
  logic              out_pop = 1'b0;
  logic              in_full;
  logic              out_empty;
  logic [1:0]        out_event_kind;
  logic [2:0]        out_button_number;
  logic signed [7:0] out_delta_x;
  logic signed [8:0] out_delta_y;
  logic              out_last_event;

  int   fail_count;
  int   pending;
  int   checked;
  int   cycle_count = 0;
  int   pop_hold = 0;
  int   aux_sent = 0;
  int   noise_sent = 0;
  bit   calm = 1'b0;
  logic [3:0] last_buttons = 4'd0;

  always #1 clk = ~clk;

  ps2_mouse_packet_decoder dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_aux_flag(in_aux_flag), .in_data_byte(in_data_byte),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_event_kind(out_event_kind), .out_button_number(out_button_number),
    .out_delta_x(out_delta_x), .out_delta_y(out_delta_y),
    .out_last_event(out_last_event)
  );

  mouse_event_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_aux_flag(in_aux_flag), .in_data_byte(in_data_byte),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_event_kind(out_event_kind), .out_button_number(out_button_number),
    .out_delta_x(out_delta_x), .out_delta_y(out_delta_y),
    .out_last_event(out_last_event),
    .fail_count(fail_count), .pending(pending), .checked(checked)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // hold pop low for random stretches
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
      pop_hold <= 0;
    end else if (pop_hold > 0) begin
      out_pop <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else begin
      out_pop <= 1'b1;
      pop_hold <= pick_gap();
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Timeout after %0d cycles with %0d events outstanding", cycle_count, pending);
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_byte(input logic aux, input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_aux_flag <= aux;
    in_data_byte <= b;
    do @(posedge clk); while (in_full);
    if (aux) aux_sent++;
    else noise_sent++;
  endtask

  task automatic send_packet(input logic [7:0] status, input logic [7:0] dx,
                             input logic [7:0] dy, input int noise_pct);
    send_byte(1'b1, status);
    if ($urandom_range(0, 99) < noise_pct) send_byte(1'b0, 8'($urandom));
    send_byte(1'b1, dx);
    if ($urandom_range(0, 99) < noise_pct) send_byte(1'b0, 8'($urandom));
    send_byte(1'b1, dy);
    last_buttons = status[3:0];
  endtask

  function automatic logic [7:0] rand_delta();
    if ($urandom_range(0, 99) < 30) return 8'd0;
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    logic [7:0] status;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: drop non-aux bytes, delta extremes, every button press and release
    send_byte(1'b0, 8'hFF);
    send_byte(1'b0, 8'h00);
    send_packet(8'h01, 8'h00, 8'h00, 0);
    send_packet(8'hF1, 8'h7F, 8'h80, 0);
    send_packet(8'h0F, 8'h80, 8'h7F, 0);
    send_packet(8'h00, 8'hFF, 8'h01, 0);
    send_packet(8'hF0, 8'h00, 8'h00, 0);
    send_packet(8'h0A, 8'h00, 8'hFF, 0);
    send_packet(8'h05, 8'h01, 8'h00, 0);
    send_byte(1'b1, 8'h00);
    send_byte(1'b0, 8'hAA);
    send_byte(1'b1, 8'h55);
    send_byte(1'b1, 8'h00);

    // random packets with occasional noise and stray aux bytes
    for (int p = 0; p < 50; p++) begin
      if (p % 8 == 0) calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 4) send_byte(1'b1, 8'($urandom));
      if ($urandom_range(0, 99) < 10) send_byte(1'b0, 8'($urandom));
      status[7:4] = 4'($urandom);
      status[3:0] = ($urandom_range(0, 99) < 40) ? last_buttons : 4'($urandom);
      send_packet(status, rand_delta(), rand_delta(), 5);
    end
    calm = 1'b0;
    in_push <= 1'b0;

    do @(negedge clk); while (pending != 0);
    repeat (TailCycles) @(posedge clk);

    $display("Covered %0d aux byte transfers and %0d ignored bytes", aux_sent, noise_sent);
    $display("Compared %0d mouse events, %0d mismatches", checked, fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
design/pdec_pkg.sv
design/pdec_front.sv
design/pdec_queue.sv
design/pdec_back.sv
design/ps2_mouse_packet_decoder.sv
tb/mouse_event_checker.sv
tb/tb_ps2_mouse_packet_decoder.sv
